// ----- hw/rtl/ledfx_pkg.sv -----
// Shared types, constants and remainder tables for the LED effect frame generator.
package ledfx_pkg;

  // Effect selector carried on the input tuser
  typedef enum logic [1:0] {
    ModeOff     = 2'd0,
    ModeRainbow = 2'd1,
    ModeBreath  = 2'd2,
    ModeStrobe  = 2'd3
  } effect_mode_e;

  // Configuration register indexes
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CfgGain         = 3'd0,
    CfgRainbowIntvl = 3'd1,
    CfgBreathIntvl  = 3'd2,
    CfgStrobeIntvl  = 3'd3,
    CfgHueInc       = 3'd4
  } cfg_index_e;

  // Field widths
  localparam int unsigned TimeW  = 32;
  localparam int unsigned IntvlW = 16;
  localparam int unsigned GainW  = 4;
  localparam int unsigned PwmW   = 12;
  localparam int unsigned StepW  = 16;
  localparam int unsigned WordW  = 16;

  typedef logic [PwmW-1:0]  pwm_t;
  typedef logic [WordW-1:0] word_t;

  // Register reset values
  localparam logic [GainW-1:0]  GainRst         = 4'd15;
  localparam logic [IntvlW-1:0] RainbowIntvlRst = 16'd10;
  localparam logic [IntvlW-1:0] BreathIntvlRst  = 16'd5;
  localparam logic [IntvlW-1:0] StrobeIntvlRst  = 16'd80;
  localparam logic [PwmW-1:0]   HueIncRst       = 12'd10;

  // Colour wheel
  localparam pwm_t WheelMod  = 12'd4095;
  localparam pwm_t WheelSeg1 = 12'd1365;
  localparam pwm_t WheelSeg2 = 12'd2730;
  localparam pwm_t PwmFull   = 12'hFFF;

  // Breathing triangle: period 2000 ms, half period 1000 ms
  localparam int unsigned BreathPeriod = 2000;
  localparam int unsigned PhaseW       = 11;
  localparam int unsigned DistW        = 10;
  localparam int unsigned RemSumW      = 13;
  localparam logic [PhaseW-1:0]  BreathHalf = 11'd1000;
  localparam logic [RemSumW-1:0] Period1 = 13'd2000;
  localparam logic [RemSumW-1:0] Period2 = 13'd4000;
  localparam logic [RemSumW-1:0] Period3 = 13'd6000;

  // floor(dist * 95 / 1000) = (dist * 19 * ceil(2^24 / 200)) >> 24, exact for dist <= 1000
  localparam int unsigned         BreathRecipW = 21;
  localparam int unsigned         BreathShift  = 24;
  localparam int unsigned         BreathProdW  = DistW + BreathRecipW;
  localparam logic [BreathRecipW-1:0] BreathRecip = 21'd1593853;

  // Remainder modulo the breathing period of one byte at a given bit position
  typedef logic [PhaseW-1:0]         rem_t;
  typedef logic [255:0][PhaseW-1:0]  rem_tab_t;

  function automatic rem_tab_t build_rem_tab(input int unsigned shift);
    rem_tab_t        tab;
    longint unsigned v;
    for (int i = 0; i < 256; i++) begin
      v      = longint'(i) << shift;
      tab[i] = rem_t'(v % BreathPeriod);
    end
    return tab;
  endfunction

  localparam rem_tab_t RemTabB1 = build_rem_tab(8);
  localparam rem_tab_t RemTabB2 = build_rem_tab(16);
  localparam rem_tab_t RemTabB3 = build_rem_tab(24);

endpackage

// ----- hw/rtl/rgb_led_effect_frame_generator_top.sv -----
// Top level of the RGB LED effect frame generator: timestamp and mode in, RGB frame out.
//
// Each input transaction passes from the input register through the effect logic into the
//   output register, which holds its frame where it produces one.
// Throughput: one input transaction per cycle while the sink does not stall the output;
//   a single pass through the effect logic between the two registers sets that figure.
// Items whose interval has not elapsed produce no frame and need no output space.
// Reset (rst_ni low, asynchronous) empties both registers, restores the register
//   defaults and clears the last-update timestamp and the shared step counter.
module rgb_led_effect_frame_generator_top
  import ledfx_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,

  // Input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [31:0]         s_axis_tdata,   // [31:0] now_ms
  input  logic [7:0]          s_axis_tuser,   // [1:0] effect_mode, rest zero

  // Output stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [47:0]         m_axis_tdata,   // [15:0] red_word, [31:16] green_word,
                                              // [47:32] blue_word

  // Configuration write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // ---------------------------------------------------------------------------
  // Configuration registers: always ready, unknown indexes drop silently
  // ---------------------------------------------------------------------------
  logic [GainW-1:0]  gain_q;
  logic [IntvlW-1:0] rainbow_intvl_q;
  logic [IntvlW-1:0] breath_intvl_q;
  logic [IntvlW-1:0] strobe_intvl_q;
  pwm_t              hue_inc_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q          <= GainRst;
      rainbow_intvl_q <= RainbowIntvlRst;
      breath_intvl_q  <= BreathIntvlRst;
      strobe_intvl_q  <= StrobeIntvlRst;
      hue_inc_q       <= HueIncRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_e'(cfg_index_i))
        CfgGain:         gain_q          <= cfg_data_i[GainW-1:0];
        CfgRainbowIntvl: rainbow_intvl_q <= cfg_data_i[IntvlW-1:0];
        CfgBreathIntvl:  breath_intvl_q  <= cfg_data_i[IntvlW-1:0];
        CfgStrobeIntvl:  strobe_intvl_q  <= cfg_data_i[IntvlW-1:0];
        CfgHueInc:       hue_inc_q       <= cfg_data_i[PwmW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input register: holds one transaction until the effect logic consumes it
  // ---------------------------------------------------------------------------
  logic               in_valid_q;
  logic [TimeW-1:0]   in_now_q;
  effect_mode_e       in_mode_q;
  logic               in_fire;     // item leaves the input register this cycle
  logic               has_result;  // item produces a frame
  logic               out_free;

  assign s_axis_tready = !in_valid_q || in_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_now_q  <= s_axis_tdata;
      in_mode_q <= effect_mode_e'(s_axis_tuser[1:0]);
    end
  end

  // ---------------------------------------------------------------------------
  // Effect state
  // ---------------------------------------------------------------------------
  logic [TimeW-1:0] last_update_q, last_update_d;
  logic [StepW-1:0] step_count_q,  step_count_d;

  // Wrapped time since the last update, compared strictly against the mode's interval
  logic [TimeW-1:0]  elapsed;
  logic [IntvlW-1:0] mode_intvl;
  logic              intvl_passed;

  assign elapsed = in_now_q - last_update_q;

  always_comb begin
    case (in_mode_q)
      ModeRainbow: mode_intvl = rainbow_intvl_q;
      ModeBreath:  mode_intvl = breath_intvl_q;
      ModeStrobe:  mode_intvl = strobe_intvl_q;
      default:     mode_intvl = '0;
    endcase
  end

  assign intvl_passed = elapsed > {{(TimeW-IntvlW){1'b0}}, mode_intvl};
  assign has_result   = (in_mode_q == ModeOff) || intvl_passed;

  // ---------------------------------------------------------------------------
  // Rainbow: wheel position advances modulo 4095 by folding the top bits back in
  // ---------------------------------------------------------------------------
  logic [StepW:0]  hue_sum;
  logic [PwmW:0]   hue_fold;
  pwm_t            wheel_pos;
  pwm_t            seg_off;
  pwm_t            ramp_up;
  pwm_t            ramp_down;
  pwm_t            rb_red, rb_green, rb_blue;

  assign hue_sum  = {1'b0, step_count_q} + {{(StepW+1-PwmW){1'b0}}, hue_inc_q};
  // 2^12 is congruent to 1 modulo 4095, so the high part adds to the low part
  assign hue_fold = {{(PwmW+1-(StepW+1-PwmW)){1'b0}}, hue_sum[StepW:PwmW]}
                  + {1'b0, hue_sum[PwmW-1:0]};
  assign wheel_pos = (hue_fold >= {1'b0, WheelMod}) ? pwm_t'(hue_fold - {1'b0, WheelMod})
                                                    : hue_fold[PwmW-1:0];

  always_comb begin
    if (wheel_pos < WheelSeg1) begin
      seg_off = wheel_pos;
    end else if (wheel_pos < WheelSeg2) begin
      seg_off = wheel_pos - WheelSeg1;
    end else begin
      seg_off = wheel_pos - WheelSeg2;
    end
  end

  // Offset stays below 1365, so three times it fits in twelve bits
  assign ramp_up   = {seg_off[PwmW-2:0], 1'b0} + seg_off;
  assign ramp_down = PwmFull - ramp_up;

  always_comb begin
    if (wheel_pos < WheelSeg1) begin
      rb_red = ramp_down; rb_green = ramp_up;   rb_blue = '0;
    end else if (wheel_pos < WheelSeg2) begin
      rb_red = '0;        rb_green = ramp_down; rb_blue = ramp_up;
    end else begin
      rb_red = ramp_up;   rb_green = '0;        rb_blue = ramp_down;
    end
  end

  // ---------------------------------------------------------------------------
  // Breathing: phase = now mod 2000 from per-byte remainder tables, then a
  // triangle scaled to full PWM by one constant multiplication
  // ---------------------------------------------------------------------------
  logic [RemSumW-1:0]     rem_sum;
  logic [PhaseW-1:0]      phase;
  logic [DistW-1:0]       tri_dist;
  logic [BreathProdW-1:0] breath_prod;
  pwm_t                   breath_pwm;

  assign rem_sum = {{(RemSumW-8){1'b0}}, in_now_q[7:0]}
                 + {{(RemSumW-PhaseW){1'b0}}, RemTabB1[in_now_q[15:8]]}
                 + {{(RemSumW-PhaseW){1'b0}}, RemTabB2[in_now_q[23:16]]}
                 + {{(RemSumW-PhaseW){1'b0}}, RemTabB3[in_now_q[31:24]]};

  always_comb begin
    if (rem_sum >= Period3) begin
      phase = PhaseW'(rem_sum - Period3);
    end else if (rem_sum >= Period2) begin
      phase = PhaseW'(rem_sum - Period2);
    end else if (rem_sum >= Period1) begin
      phase = PhaseW'(rem_sum - Period1);
    end else begin
      phase = rem_sum[PhaseW-1:0];
    end
  end

  assign tri_dist = (phase >= BreathHalf) ? DistW'(phase - BreathHalf)
                                          : DistW'(BreathHalf - phase);

  // tri_dist * 4095 / 1000 = 4 * tri_dist + floor(tri_dist * 95 / 1000)
  assign breath_prod = {{BreathRecipW{1'b0}}, tri_dist} * {{DistW{1'b0}}, BreathRecip};
  assign breath_pwm  = {tri_dist, 2'b00} + pwm_t'(breath_prod[BreathProdW-1:BreathShift]);

  // ---------------------------------------------------------------------------
  // Strobe: shared counter advances, even count red, odd count blue
  // ---------------------------------------------------------------------------
  logic [StepW-1:0] strobe_count;

  assign strobe_count = step_count_q + {{(StepW-1){1'b0}}, 1'b1};

  // ---------------------------------------------------------------------------
  // Frame selection and state update
  // ---------------------------------------------------------------------------
  pwm_t red_pwm, green_pwm, blue_pwm;

  always_comb begin
    last_update_d = last_update_q;
    step_count_d  = step_count_q;
    red_pwm       = '0;
    green_pwm     = '0;
    blue_pwm      = '0;
    case (in_mode_q)
      ModeRainbow: begin
        red_pwm   = rb_red;
        green_pwm = rb_green;
        blue_pwm  = rb_blue;
        if (in_fire && intvl_passed) begin
          last_update_d = in_now_q;
          step_count_d  = {{(StepW-PwmW){1'b0}}, wheel_pos};
        end
      end
      ModeBreath: begin
        green_pwm = breath_pwm;
        if (in_fire && intvl_passed) begin
          last_update_d = in_now_q;
        end
      end
      ModeStrobe: begin
        if (strobe_count[0]) begin
          blue_pwm = PwmFull;
        end else begin
          red_pwm  = PwmFull;
        end
        if (in_fire && intvl_passed) begin
          last_update_d = in_now_q;
          step_count_d  = strobe_count;
        end
      end
      default: ;  // off frame, state untouched
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_update_q <= '0;
      step_count_q  <= '0;
    end else begin
      last_update_q <= last_update_d;
      step_count_q  <= step_count_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: advance when empty or when the sink takes the frame
  // ---------------------------------------------------------------------------
  logic        out_valid_q;
  logic [47:0] out_data_q;

  assign out_free = !out_valid_q || m_axis_tready;
  assign in_fire  = in_valid_q && (!has_result || out_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_fire && has_result;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && has_result) begin
      out_data_q <= {gain_q, blue_pwm, gain_q, green_pwm, gain_q, red_pwm};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_frame_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && has_result |=> out_valid_q)
    else $error("frame not presented after consuming an item");

  a_wheel_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_mode_q == ModeRainbow && intvl_passed
      |=> step_count_q < {{(StepW-PwmW){1'b0}}, WheelMod})
    else $error("wheel position escaped its modulus");

  a_timestamp_recorded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_mode_q != ModeOff && intvl_passed |=> last_update_q == $past(in_now_q))
    else $error("last update timestamp not recorded");

  a_state_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_fire |=> $stable(step_count_q) && $stable(last_update_q))
    else $error("effect state changed without a consumed item");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready |=> out_valid_q && $stable(out_data_q))
    else $error("pending frame overwritten");

endmodule

// ----- tb/tb_rgb_led_effect_frame_generator_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the RGB LED effect frame generator top level.
module tb_rgb_led_effect_frame_generator_top;
  import ledfx_pkg::*;

  // Run limits and timing
  localparam int unsigned CycleLimit     = 1_000_000;
  localparam int unsigned DrainCycles    = 4;     // lets items that owed nothing leave the pipeline
  localparam int unsigned RxHoldCycles   = 300;   // long receiver hold-off for back-pressure
  localparam int unsigned PressureItems  = 40;
  localparam int unsigned RandomPhases   = 12;
  localparam int unsigned ItemsPerPhase  = 85;
  localparam int unsigned PressurePhase  = 3;
  localparam int unsigned PrintLimit     = 40;

  // Register indexes that the block must ignore
  localparam logic [CfgIdxW-1:0] CfgIdxFirstUnused = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgIdxLast        = 3'd7;

  // One LED frame, red first
  typedef struct packed {
    word_t red;
    word_t green;
    word_t blue;
  } frame_t;

  typedef enum logic {
    RowCfg,
    RowItem
  } row_kind_e;

  // One row of the directed table: either a register write or an input transaction.
  // Where known is set, the typed frame replaces the predicted one.
  typedef struct {
    row_kind_e            kind;
    logic [CfgIdxW-1:0]   idx;
    logic [CfgDataW-1:0]  data;
    logic [TimeW-1:0]     now;
    effect_mode_e         mode;
    bit                   known;
    bit                   has_frame;
    frame_t               frame;
  } stim_row_t;

  // Clock, reset and block ports; every input starts at a known value
  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [31:0]         s_axis_tdata  = '0;    // [31:0] now_ms
  logic [7:0]          s_axis_tuser  = '0;    // [1:0] effect_mode, rest zero
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [47:0]         m_axis_tdata;          // [15:0] red, [31:16] green, [47:32] blue
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;

  // Frame predictor: its own copy of the registers and of the effect state
  logic [GainW-1:0]  model_gain        = GainRst;
  logic [IntvlW-1:0] model_rainbow_ivl = RainbowIntvlRst;
  logic [IntvlW-1:0] model_breath_ivl  = BreathIntvlRst;
  logic [IntvlW-1:0] model_strobe_ivl  = StrobeIntvlRst;
  logic [PwmW-1:0]   model_hue_inc     = HueIncRst;
  logic [TimeW-1:0]  model_last_ms     = '0;
  logic [StepW-1:0]  model_step        = '0;

  // Frames still owed by the block, oldest first
  frame_t      frame_q[$];
  stim_row_t   dir_rows[$];
  int unsigned error_count   = 0;
  int unsigned cycle_count   = 0;
  int unsigned hold_requests = 0;
  bit          tx_idling     = 1'b0;
  bit          rx_idling     = 1'b0;
  frame_t      mon_got;
  frame_t      mon_want;

  rgb_led_effect_frame_generator_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // 20 ns clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Watchdog: end the run as failed once the cycle limit is reached
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------------------

  // Place the current gain nibble above each 12-bit PWM value
  function automatic frame_t pack_frame(input pwm_t red, input pwm_t green, input pwm_t blue);
    frame_t fr;
    fr.red   = {model_gain, red};
    fr.green = {model_gain, green};
    fr.blue  = {model_gain, blue};
    return fr;
  endfunction

  // Work out the frame for one accepted transaction and advance the effect state.
  // Returns 0 where the mode's interval has not yet elapsed.
  function automatic bit predict_frame(input logic [TimeW-1:0] now, input effect_mode_e mode,
                                       output frame_t fr);
    logic [31:0] elapsed;
    logic [31:0] pos;
    logic [31:0] phase;
    logic [31:0] ramp_dist;
    elapsed = now - model_last_ms;
    fr      = pack_frame('0, '0, '0);
    case (mode)
      ModeRainbow: begin
        if (elapsed <= 32'(model_rainbow_ivl)) return 1'b0;
        model_last_ms = now;
        // the shared counter may hold a strobe count above the wheel size: reduce it here
        model_step = StepW'((32'(model_step) + 32'(model_hue_inc)) % 32'(WheelMod));
        pos        = 32'(model_step);
        if (pos < 32'(WheelSeg1)) begin
          fr = pack_frame(pwm_t'(32'(PwmFull) - pos * 3), pwm_t'(pos * 3), '0);
        end else if (pos < 32'(WheelSeg2)) begin
          pos = pos - 32'(WheelSeg1);
          fr  = pack_frame('0, pwm_t'(32'(PwmFull) - pos * 3), pwm_t'(pos * 3));
        end else begin
          pos = pos - 32'(WheelSeg2);
          fr  = pack_frame(pwm_t'(pos * 3), '0, pwm_t'(32'(PwmFull) - pos * 3));
        end
        return 1'b1;
      end
      ModeBreath: begin
        if (elapsed <= 32'(model_breath_ivl)) return 1'b0;
        model_last_ms = now;
        phase     = now % BreathPeriod;
        ramp_dist = (phase >= 32'(BreathHalf)) ? phase - 32'(BreathHalf)
                                               : 32'(BreathHalf) - phase;
        fr = pack_frame('0, pwm_t'((ramp_dist * 32'(PwmFull)) / 32'(BreathHalf)), '0);
        return 1'b1;
      end
      ModeStrobe: begin
        if (elapsed <= 32'(model_strobe_ivl)) return 1'b0;
        model_last_ms = now;
        model_step    = model_step + 1'b1;
        fr = model_step[0] ? pack_frame('0, '0, PwmFull) : pack_frame(PwmFull, '0, '0);
        return 1'b1;
      end
      default: begin
        // off: always a frame, gain kept, state untouched
        return 1'b1;
      end
    endcase
  endfunction

  // Mirror one register write; unknown indexes are dropped
  function automatic void apply_reg(input logic [CfgIdxW-1:0] idx,
                                    input logic [CfgDataW-1:0] data);
    case (idx)
      CfgGain:         model_gain        = data[GainW-1:0];
      CfgRainbowIntvl: model_rainbow_ivl = data[IntvlW-1:0];
      CfgBreathIntvl:  model_breath_ivl  = data[IntvlW-1:0];
      CfgStrobeIntvl:  model_strobe_ivl  = data[IntvlW-1:0];
      CfgHueInc:       model_hue_inc     = data[PwmW-1:0];
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input word_t got, input word_t want);
    error_count++;
    if (error_count <= PrintLimit)
      $display("%0t ns: %s mismatch, got %h, expected %h", $time, what, got, want);
  endtask

  // Compare every output transaction with the oldest frame owed
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      mon_got.red   = m_axis_tdata[15:0];
      mon_got.green = m_axis_tdata[31:16];
      mon_got.blue  = m_axis_tdata[47:32];
      if (frame_q.size() == 0) begin
        report_mismatch("unrequested frame, red", mon_got.red, '0);
      end else begin
        mon_want = frame_q.pop_front();
        if (mon_got.red !== mon_want.red)
          report_mismatch("red_word", mon_got.red, mon_want.red);
        if (mon_got.green !== mon_want.green)
          report_mismatch("green_word", mon_got.green, mon_want.green);
        if (mon_got.blue !== mon_want.blue)
          report_mismatch("blue_word", mon_got.blue, mon_want.blue);
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off on request
  // ---------------------------------------------------------------------------------------

  // Mostly short gaps, now and then a long one
  function automatic int unsigned idle_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_requests > 0) begin
        // hold off for a long stretch so that the block fills and stalls its input
        hold_requests--;
        m_axis_tready <= 1'b0;
        repeat (RxHoldCycles - 1) @(negedge clk_i);
      end else if (rx_idling && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat (idle_len() - 1) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Sender and register writer
  // ---------------------------------------------------------------------------------------

  // Offer one transaction, wait for its handshake, then record the frame it owes.
  // Leave tvalid high: the caller either offers the next item or drops it.
  task automatic send_item(input logic [TimeW-1:0] now, input effect_mode_e mode,
                           input bit known, input bit known_has, input frame_t known_fr);
    frame_t fr;
    bit     has;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= now;
    s_axis_tuser  <= {6'b0, mode};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    has = predict_frame(now, mode, fr);
    if (known) begin
      has = known_has;
      fr  = known_fr;
    end
    if (has) frame_q.push_back(fr);
  endtask

  // Drop tvalid for a number of cycles
  task automatic pause_input(input int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
  endtask

  // Stop offering, collect every frame owed, then let the pipeline empty of items
  // that owed nothing
  task automatic wait_idle();
    pause_input(1);
    while (frame_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    apply_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------------------
  // Random stimulus
  // ---------------------------------------------------------------------------------------

  // Phase 0 takes every register at its minimum, phase 1 at its maximum
  function automatic logic [IntvlW-1:0] pick_ivl(input int unsigned phase_no);
    if (phase_no == 0) return '0;
    if (phase_no == 1) return '1;
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return IntvlW'($urandom_range(1, 30));
      default: return IntvlW'($urandom_range(31, 700));
    endcase
  endfunction

  task automatic random_config(input int unsigned phase_no);
    logic [GainW-1:0] gain;
    logic [PwmW-1:0]  hue;
    gain = (phase_no == 0) ? '0 : (phase_no == 1) ? '1 : GainW'($urandom_range(0, 15));
    if (phase_no == 0)
      hue = '0;
    else if (phase_no == 1)
      hue = '1;
    else begin
      case ($urandom_range(0, 5))
        0:       hue = '1;                   // equal to the wheel size
        1:       hue = WheelMod - 1'b1;
        2:       hue = '0;
        default: hue = PwmW'($urandom_range(0, 4095));
      endcase
    end
    wait_idle();
    // upper data bits beyond each register's width must be dropped
    write_reg(CfgGain, {12'($urandom), gain});
    write_reg(CfgRainbowIntvl, pick_ivl(phase_no));
    write_reg(CfgBreathIntvl, pick_ivl(phase_no));
    write_reg(CfgStrobeIntvl, pick_ivl(phase_no));
    write_reg(CfgHueInc, {4'($urandom), hue});
    if ($urandom_range(0, 1) == 0)
      write_reg(CfgIdxW'($urandom_range(CfgIdxFirstUnused, CfgIdxLast)), 16'($urandom));
  endtask

  // Mostly timestamps placed around the chosen mode's interval, measured from the
  // last update, with some noise: any time, times near the 32-bit wrap, off frames
  function automatic void gen_item(output logic [TimeW-1:0] now, output effect_mode_e mode);
    int unsigned pick;
    int unsigned ivl;
    int unsigned delta;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      mode = effect_mode_e'($urandom_range(0, 3));
      now  = $urandom_range(0, 1) ? $urandom : 32'hFFFF_FFFF - $urandom_range(0, 500);
    end else if (pick < 15) begin
      mode = ModeOff;
      now  = $urandom;
    end else begin
      mode = effect_mode_e'($urandom_range(1, 3));
      ivl  = (mode == ModeRainbow) ? model_rainbow_ivl :
             (mode == ModeBreath)  ? model_breath_ivl  : model_strobe_ivl;
      case ($urandom_range(0, 9))
        0, 1:    delta = ivl;
        2, 3:    delta = ivl + 1;
        4, 5, 6: delta = $urandom_range(0, ivl);
        default: delta = ivl + 1 + $urandom_range(0, 600);
      endcase
      now = model_last_ms + delta;
    end
  endfunction

  task automatic run_phase(input int unsigned phase_no);
    logic [TimeW-1:0] now;
    effect_mode_e     mode;
    bit               pressure;
    pressure = (phase_no == PressurePhase);
    if (pressure) hold_requests++;
    for (int unsigned i = 0; i < ItemsPerPhase; i++) begin
      gen_item(now, mode);
      send_item(now, mode, 1'b0, 1'b0, '0);
      // the first PressureItems items of the pressure phase go back to back
      if (tx_idling && !(pressure && i < PressureItems) && $urandom_range(0, 2) == 0)
        pause_input(idle_len());
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------------------

  function automatic stim_row_t cfg_row(input logic [CfgIdxW-1:0] idx,
                                        input logic [CfgDataW-1:0] data);
    stim_row_t row;
    row       = '{kind: RowCfg, idx: idx, data: data, now: '0, mode: ModeOff, known: 1'b0,
                  has_frame: 1'b0, frame: '0};
    return row;
  endfunction

  function automatic stim_row_t item_row(input logic [TimeW-1:0] now, input effect_mode_e mode,
                                         input bit known, input bit has_frame,
                                         input word_t red, input word_t green,
                                         input word_t blue);
    stim_row_t row;
    row       = '{kind: RowItem, idx: '0, data: '0, now: now, mode: mode, known: known,
                  has_frame: has_frame, frame: '{red, green, blue}};
    return row;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------------------

  initial begin
    // Directed part, starting from the reset state (gain 15, intervals 10/5/80, hue 10)
    dir_rows.push_back(item_row(32'd0,  ModeOff,     1, 1, 16'hF000, 16'hF000, 16'hF000));
    // rainbow: interval reached but not exceeded, then exceeded by one
    dir_rows.push_back(item_row(32'd10, ModeRainbow, 1, 0, '0, '0, '0));
    dir_rows.push_back(item_row(32'd11, ModeRainbow, 1, 1, 16'hFFE1, 16'hF01E, 16'hF000));
    dir_rows.push_back(item_row(32'd16, ModeBreath,  1, 0, '0, '0, '0));
    dir_rows.push_back(item_row(32'd17, ModeBreath,  0, 0, '0, '0, '0));
    dir_rows.push_back(item_row(32'd97, ModeStrobe,  1, 0, '0, '0, '0));
    dir_rows.push_back(item_row(32'd98, ModeStrobe,  1, 1, 16'hF000, 16'hF000, 16'hFFFF));
    // off leaves the last-update time alone
    dir_rows.push_back(item_row(32'hFFFF_FFFF, ModeOff, 1, 1, 16'hF000, 16'hF000, 16'hF000));
    // breathing trough and peak of the triangle
    dir_rows.push_back(item_row(32'd1000, ModeBreath, 1, 1, 16'hF000, 16'hF000, 16'hF000));
    dir_rows.push_back(item_row(32'd2000, ModeBreath, 1, 1, 16'hF000, 16'hFFFF, 16'hF000));
    dir_rows.push_back(item_row(32'hFFFF_FFFF, ModeBreath, 0, 0, '0, '0, '0));
    // elapsed time across the 32-bit wrap
    dir_rows.push_back(item_row(32'd80, ModeStrobe, 1, 1, 16'hFFFF, 16'hF000, 16'hF000));
    dir_rows.push_back(cfg_row(CfgGain, 16'h0000));
    dir_rows.push_back(cfg_row(CfgRainbowIntvl, 16'h0000));
    dir_rows.push_back(cfg_row(CfgStrobeIntvl, 16'h0000));
    dir_rows.push_back(cfg_row(CfgBreathIntvl, 16'hFFFF));
    dir_rows.push_back(cfg_row(CfgHueInc, 16'd4083));
    // zero interval: same timestamp is not an elapse
    dir_rows.push_back(item_row(32'd80, ModeRainbow, 1, 0, '0, '0, '0));
    dir_rows.push_back(item_row(32'd81, ModeRainbow, 1, 1, 16'h0FFF, 16'h0000, 16'h0000));
    dir_rows.push_back(cfg_row(CfgHueInc, 16'd4094));
    dir_rows.push_back(item_row(32'd82, ModeRainbow, 1, 1, 16'h0FFC, 16'h0000, 16'h0003));
    // strobe pushes the shared counter to the wheel size
    dir_rows.push_back(item_row(32'd83, ModeStrobe, 1, 1, 16'h0000, 16'h0000, 16'h0FFF));
    // increment above the wheel range on a counter at the wheel size
    dir_rows.push_back(cfg_row(CfgHueInc, 16'h0FFF));
    dir_rows.push_back(item_row(32'd84, ModeRainbow, 1, 1, 16'h0FFF, 16'h0000, 16'h0000));
    // both colour segment boundaries
    dir_rows.push_back(cfg_row(CfgHueInc, 16'd1365));
    dir_rows.push_back(item_row(32'd85, ModeRainbow, 1, 1, 16'h0000, 16'h0FFF, 16'h0000));
    dir_rows.push_back(item_row(32'd86, ModeRainbow, 1, 1, 16'h0000, 16'h0000, 16'h0FFF));
    // longest interval: equal, then one beyond
    dir_rows.push_back(item_row(32'd65621, ModeBreath, 1, 0, '0, '0, '0));
    dir_rows.push_back(item_row(32'd65622, ModeBreath, 0, 0, '0, '0, '0));
    // upper data bits dropped, unknown index ignored
    dir_rows.push_back(cfg_row(CfgGain, 16'hFFF5));
    dir_rows.push_back(cfg_row(CfgIdxLast, 16'hFFFF));
    dir_rows.push_back(cfg_row(CfgHueInc, 16'hF00A));
    dir_rows.push_back(item_row(32'd0, ModeOff, 1, 1, 16'h5000, 16'h5000, 16'h5000));
    dir_rows.push_back(item_row(32'd65623, ModeRainbow, 0, 0, '0, '0, '0));

    // Hold reset, then release it on a falling edge
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == RowCfg) begin
        wait_idle();
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        send_item(dir_rows[i].now, dir_rows[i].mode, dir_rows[i].known,
                  dir_rows[i].has_frame, dir_rows[i].frame);
        pause_input(1);
      end
    end

    // Random phases, each under a fresh register setting and idling pattern
    for (int unsigned p = 0; p < RandomPhases; p++) begin
      random_config(p);
      tx_idling = (p % 3 != 0);
      rx_idling = (p % 4 != 1) || (p == PressurePhase);
      run_phase(p);
    end

    // Collect what is still owed, let the pipeline settle, then conclude
    wait_idle();
    repeat (2 * DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/ledfx_pkg.sv
hw/rtl/rgb_led_effect_frame_generator_top.sv
tb/tb_rgb_led_effect_frame_generator_top.sv
